// ===== hdl/eemi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extended Euclid package
// Shared types and codes for the modular inverse controller and datapath.
// ----------------------------------------------------------------------------
package eemi_pkg;

   // Inverse status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_GCD     = 2'd1;
   localparam logic [1:0] STATUS_MODULUS = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture operands
      logic div_start; // load divider with |r0| / |r1|
      logic div_step;  // one restoring division step
      logic mul_step;  // one shift-add multiply step for r, x, y
      logic mul_start; // set up the multiply for the new quotient
      logic rotate;    // commit the round
      logic fix_sign;  // negate results when the gcd is negative
      logic mod_start; // start |x0| mod b
      logic finish;    // form status and inverse
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic r1_zero;
   } dp_status_type;

endpackage

// ===== hdl/eemi_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extended Euclid datapath
// Remainder and coefficient registers, a bit-serial divider and a bit-serial
// multiplier shared by every round.
// ----------------------------------------------------------------------------
module eemi_datapath #(
   parameter int WORD_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  eemi_pkg::dp_cmd_type   cmd,
   output eemi_pkg::dp_status_type status,
   input  logic [63:0]            value_a,
   input  logic [63:0]            value_b,
   output logic [62:0]            gcd_value,
   output logic [63:0]            coef_a,
   output logic [63:0]            coef_b,
   output logic [62:0]            inverse_value,
   output logic [1:0]             inverse_status
);
   import eemi_pkg::*;

   localparam int W = WORD_BITS;

   logic [W-1:0] r0_ff, r1_ff, x0_ff, x1_ff, y0_ff, y1_ff, b_ff;
   logic [W-1:0] r0_in, r1_in, x0_in, x1_in, y0_in, y1_in, b_in;
   // Divider: remainder, quotient/dividend shift register, divisor.
   logic [W-1:0] rem_ff, quo_ff, dvs_ff, rem_in, quo_in, dvs_in;
   logic         qneg_ff, qneg_in;
   // Multiplier: quotient shifted right, multiplicands shifted left, products.
   logic [W-1:0] mq_ff, mr_ff, mx_ff, my_ff, pr_ff, px_ff, py_ff;
   logic [W-1:0] mq_in, mr_in, mx_in, my_in, pr_in, px_in, py_in;
   logic [62:0]  gcd_ff, inv_ff, gcd_in, inv_in;
   logic [63:0]  ca_ff, cb_ff, ca_in, cb_in;
   logic [1:0]   st_ff, st_in;

   logic [W:0]   trial;
   logic [W-1:0] rem_sh, mag_r0, mag_r1, mag_x0, quo_n;

   function automatic logic [W-1:0] fmag(input logic [W-1:0] v);
      fmag = v[W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [63:0] sext(input logic [W-1:0] v);
      sext = 64'($signed(v));
   endfunction

   assign mag_r0 = fmag(r0_ff);
   assign mag_r1 = fmag(r1_ff);
   assign mag_x0 = fmag(x0_ff);
   assign rem_sh = {rem_ff[W-2:0], quo_ff[W-1]};
   assign trial  = {1'b0, rem_sh} - {1'b0, dvs_ff};
   assign quo_n  = qneg_ff ? (~quo_ff + 1'b1) : quo_ff;

   // Next-state logic for the whole datapath.
   always_comb begin
      r0_in = r0_ff; r1_in = r1_ff; x0_in = x0_ff; x1_in = x1_ff;
      y0_in = y0_ff; y1_in = y1_ff; b_in = b_ff;
      rem_in = rem_ff; quo_in = quo_ff; dvs_in = dvs_ff; qneg_in = qneg_ff;
      mq_in = mq_ff; mr_in = mr_ff; mx_in = mx_ff; my_in = my_ff;
      pr_in = pr_ff; px_in = px_ff; py_in = py_ff;
      gcd_in = gcd_ff; inv_in = inv_ff; ca_in = ca_ff; cb_in = cb_ff; st_in = st_ff;
      if (cmd.load) begin
         r0_in = value_a[W-1:0]; r1_in = value_b[W-1:0]; b_in = value_b[W-1:0];
         x0_in = W'(1); x1_in = '0; y0_in = '0; y1_in = W'(1);
      end
      if (cmd.div_start) begin
         rem_in = '0; quo_in = mag_r0; dvs_in = mag_r1;
         qneg_in = r0_ff[W-1] ^ r1_ff[W-1];
      end
      if (cmd.mod_start) begin
         rem_in = '0; quo_in = mag_x0; dvs_in = b_ff; qneg_in = 1'b0;
      end
      if (cmd.div_step) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0]; quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh; quo_in = {quo_ff[W-2:0], 1'b0};
         end
      end
      if (cmd.mul_start) begin
         mq_in = quo_n; mr_in = r1_ff; mx_in = x1_ff; my_in = y1_ff;
         pr_in = '0; px_in = '0; py_in = '0;
      end
      if (cmd.mul_step) begin
         if (mq_ff[0]) begin
            pr_in = pr_ff + mr_ff; px_in = px_ff + mx_ff; py_in = py_ff + my_ff;
         end
         mq_in = mq_ff >> 1;
         mr_in = mr_ff << 1; mx_in = mx_ff << 1; my_in = my_ff << 1;
      end
      if (cmd.rotate) begin
         r0_in = r1_ff; r1_in = r0_ff - pr_ff;
         x0_in = x1_ff; x1_in = x0_ff - px_ff;
         y0_in = y1_ff; y1_in = y0_ff - py_ff;
      end
      if (cmd.fix_sign && r0_ff[W-1]) begin
         r0_in = ~r0_ff + 1'b1; x0_in = ~x0_ff + 1'b1; y0_in = ~y0_ff + 1'b1;
      end
      if (cmd.finish) begin
         gcd_in = 63'(sext(r0_ff));
         ca_in = sext(x0_ff); cb_in = sext(y0_ff);
         inv_in = '0;
         if (b_ff == '0 || b_ff[W-1]) begin
            st_in = STATUS_MODULUS;
         end else if (r0_ff != W'(1)) begin
            st_in = STATUS_GCD;
         end else begin
            st_in = STATUS_OK;
            if (x0_ff[W-1] && rem_ff != '0) begin
               inv_in = 63'(sext(b_ff - rem_ff));
            end else begin
               inv_in = 63'(sext(rem_ff));
            end
         end
      end
   end

   // Datapath registers; none need reset.
   always_ff @(posedge clock) begin
      r0_ff <= r0_in; r1_ff <= r1_in; x0_ff <= x0_in; x1_ff <= x1_in;
      y0_ff <= y0_in; y1_ff <= y1_in; b_ff <= b_in;
      rem_ff <= rem_in; quo_ff <= quo_in; dvs_ff <= dvs_in; qneg_ff <= qneg_in;
      mq_ff <= mq_in; mr_ff <= mr_in; mx_ff <= mx_in; my_ff <= my_in;
      pr_ff <= pr_in; px_ff <= px_in; py_ff <= py_in;
      gcd_ff <= gcd_in; inv_ff <= inv_in; ca_ff <= ca_in; cb_ff <= cb_in;
      st_ff <= st_in;
   end

   assign status.r1_zero = (r1_ff == '0) && !reset;
   assign gcd_value      = gcd_ff;
   assign coef_a         = ca_ff;
   assign coef_b         = cb_ff;
   assign inverse_value  = inv_ff;
   assign inverse_status = st_ff;

endmodule

// ===== hdl/eemi_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extended Euclid controller
// Sequences rounds of divide, multiply and update, then the final reduction.
// ----------------------------------------------------------------------------
module eemi_control #(
   parameter int WORD_BITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output eemi_pkg::dp_cmd_type    cmd,
   input  eemi_pkg::dp_status_type status
);
   import eemi_pkg::*;

   localparam int CW = $clog2(WORD_BITS + 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_CHECK = 8'b0000_0010,
      S_DIV   = 8'b0000_0100,
      S_MUL   = 8'b0000_1000,
      S_ROT   = 8'b0001_0000,
      S_MOD   = 8'b0010_0000,
      S_FIN   = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic         fixed_ff, fixed_in;

   // State sequencing and command decode.
   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; fixed_in = fixed_ff;
      cmd = '0;
      in_ready = 1'b0; out_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1; state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!status.r1_zero) begin
               cmd.div_start = 1'b1; cnt_in = CW'(WORD_BITS); state_in = S_DIV;
            end else begin
               cmd.fix_sign = 1'b1; fixed_in = 1'b1; state_in = S_MOD;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1; cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = fixed_ff ? S_FIN : S_MUL;
               cnt_in = CW'(WORD_BITS);
            end
         end
         S_MUL: begin
            if (cnt_ff == CW'(WORD_BITS)) begin
               cmd.mul_start = 1'b1; cnt_in = cnt_ff - 1'b1;
            end else begin
               cmd.mul_step = 1'b1; cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == '0) state_in = S_ROT;
            end
         end
         S_ROT: begin
            cmd.rotate = 1'b1; state_in = S_CHECK;
         end
         S_MOD: begin
            cmd.mod_start = 1'b1; cnt_in = CW'(WORD_BITS); state_in = S_DIV;
         end
         S_FIN: begin
            cmd.finish = 1'b1; fixed_in = 1'b0; state_in = S_OUT;
         end
         S_OUT: begin
            out_valid = 1'b1;
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; fixed_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; fixed_ff <= fixed_in;
      end
   end

endmodule

// ===== hdl/extended_euclid_modular_inverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extended Euclid modular inverse
// Returns gcd, Bezout coefficients and the inverse of a modulo b.
// ----------------------------------------------------------------------------
// One item at a time. Each Euclid round runs the bit-serial divider, then
// the shared shift-add multiplier, then the update; after the last round
// the sign fix and the final reduction in the divider follow. The result
// is held in an output register until taken.
module extended_euclid_modular_inverse #(
   parameter int WORD_BITS = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,  // value_a[63:0], value_b[127:64]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [255:0]  rsp_tdata   // gcd_value[62:0], coef_a[126:63],
                                     // coef_b[190:127], inverse_value[253:191],
                                     // inverse_status[255:254]
);
   import eemi_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [62:0] gcd_value, inverse_value;
   logic [63:0] coef_a, coef_b;
   logic [1:0]  inverse_status;

   eemi_control #(.WORD_BITS(WORD_BITS)) u_control (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .cmd, .status
   );

   eemi_datapath #(.WORD_BITS(WORD_BITS)) u_datapath (
      .clock, .reset, .cmd, .status,
      .value_a(req_tdata[63:0]), .value_b(req_tdata[127:64]),
      .gcd_value, .coef_a, .coef_b, .inverse_value, .inverse_status
   );

   assign rsp_tdata = {inverse_status, inverse_value, coef_b, coef_a, gcd_value};

endmodule

// ===== bench/extended_euclid_modular_inverse_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extended Euclid modular inverse testbench
// Drives operand pairs into the block under random stalls on both sides and
// checks every result item against a behavioral Euclid predictor.
// ----------------------------------------------------------------------------

// Result item as it travels on rsp_tdata.
typedef struct packed {
   logic [1:0]  inverse_status;
   logic [62:0] inverse_value;
   logic [63:0] coef_b;
   logic [63:0] coef_a;
   logic [62:0] gcd_value;
} euclid_result_type;

// Holds expected results in order and compares each arriving one.
class euclid_scoreboard;
   euclid_result_type pending_results[$];
   int error_count = 0;

   // Signed 64-bit extended Euclid with wrapping arithmetic.
   function euclid_result_type predict(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [63:0] r0, r1, r2, x0, x1, x2, y0, y1, y2, quot, rem_mag;
      logic [63:0] mag_p, mag_d, uq;
      euclid_result_type res;
      r0 = a; r1 = b; x0 = 1; x1 = 0; y0 = 0; y1 = 1;
      while (r1 != 0) begin
         mag_p = r0[63] ? -r0 : r0;
         mag_d = r1[63] ? -r1 : r1;
         uq = mag_p / mag_d;
         quot = (r0[63] != r1[63]) ? -uq : uq;
         r2 = r0 - quot * r1;
         x2 = x0 - quot * x1;
         y2 = y0 - quot * y1;
         r0 = r1; r1 = r2; x0 = x1; x1 = x2; y0 = y1; y1 = y2;
      end
      if (r0[63]) begin
         r0 = -r0; x0 = -x0; y0 = -y0;
      end
      res = '0;
      res.gcd_value = r0[62:0];
      res.coef_a = x0;
      res.coef_b = y0;
      if (b <= 0) begin
         res.inverse_status = eemi_pkg::STATUS_MODULUS;
      end else if (r0 != 1) begin
         res.inverse_status = eemi_pkg::STATUS_GCD;
      end else begin
         mag_p = x0[63] ? -x0 : x0;
         rem_mag = mag_p % b;
         res.inverse_status = eemi_pkg::STATUS_OK;
         res.inverse_value = 63'((x0[63] && rem_mag != 0) ? b - rem_mag : rem_mag);
      end
      return res;
   endfunction

   function void note_operands(logic [127:0] data);
      pending_results.push_back(predict(data[63:0], data[127:64]));
   endfunction

   function void check_result(logic [255:0] data);
      euclid_result_type got, want;
      got = data;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result %h", $time, data);
         error_count++;
         return;
      end
      want = pending_results.pop_front();
      if (got.gcd_value !== want.gcd_value) begin
         $display("%0t: gcd_value expected %h actual %h", $time, want.gcd_value, got.gcd_value);
         error_count++;
      end
      if (got.coef_a !== want.coef_a) begin
         $display("%0t: coef_a expected %h actual %h", $time, want.coef_a, got.coef_a);
         error_count++;
      end
      if (got.coef_b !== want.coef_b) begin
         $display("%0t: coef_b expected %h actual %h", $time, want.coef_b, got.coef_b);
         error_count++;
      end
      if (got.inverse_value !== want.inverse_value) begin
         $display("%0t: inverse_value expected %h actual %h", $time,
                  want.inverse_value, got.inverse_value);
         error_count++;
      end
      if (got.inverse_status !== want.inverse_status) begin
         $display("%0t: inverse_status expected %0d actual %0d", $time,
                  want.inverse_status, got.inverse_status);
         error_count++;
      end
   endfunction
endclass

module extended_euclid_modular_inverse_tb;
   localparam longint CYCLE_LIMIT = 10_000_000;
   localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [127:0]  req_tdata = '0;   // value_a[63:0], value_b[127:64]
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [255:0]  rsp_tdata;        // gcd, coef_a, coef_b, inverse, status

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_receiver = 1'b0;
   longint cycle_count = 0;
   euclid_scoreboard board;

   extended_euclid_modular_inverse uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #2 clock = ~clock;

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_result(rsp_tdata);
      end
      if (hold_receiver) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one operand pair and wait until it is taken. The valid stays up
   // after the item is taken until the next idle cycle or the next item.
   task automatic send_pair(logic [63:0] a, logic [63:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {b, a};
      do @(posedge clock); while (!req_tready);
      board.note_operands({b, a});
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
   endtask

   // Mostly modest operands, some full-width ones.
   function automatic logic [63:0] random_operand();
      case ($urandom_range(3))
         0: return {$urandom, $urandom};
         1: return 64'(signed'($urandom_range(2000)) - 1000);
         2: return {32'($signed($urandom) >>> 31), $urandom};
         default: return {$urandom, $urandom} >> $urandom_range(63);
      endcase
   endfunction

   task automatic random_phase(int count, int s_pct, int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (count) send_pair(random_operand(), random_operand());
   endtask

   initial begin
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners: zeros, units, extremes, negative moduli.
      send_pair(0, 0);
      send_pair(5, 0);
      send_pair(0, 7);
      send_pair(3, 1);
      send_pair(3, 7);
      send_pair(-3, 7);
      send_pair(4, 8);
      send_pair(3, -7);
      send_pair(MOST_NEG, MOST_NEG);
      send_pair(MOST_NEG, -1);
      send_pair(-1, MOST_NEG);
      send_pair(MOST_NEG, 0);
      send_pair(MOST_POS, MOST_POS - 1);
      send_pair(MOST_POS, MOST_NEG);
      send_pair(64'hffff_ffff_ffff_ffff, MOST_POS);
      send_pair(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaab);
      // Consecutive Fibonacci numbers give the longest runs of rounds.
      send_pair(64'd7540113804746346429, 64'd4660046610375530309);
      send_pair(17, 3120);

      // Sender pauses until everything is back.
      wait_drained();

      // Hold the receiver off while the sender keeps offering items.
      hold_receiver = 1'b1;
      fork
         begin
            repeat (60000) @(posedge clock);
            hold_receiver = 1'b0;
         end
         random_phase(4, 0, 0);
      join

      random_phase(30, 33, 50);
      random_phase(30, 50, 33);
      random_phase(18, 0, 0);

      wait_drained();
      repeat (20000) @(posedge clock);
      if (board.error_count == 0 && board.pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
